// ===== hw/rtl/dcfd_pkg.sv =====
// Shared types, constants and configuration records of the DShot capture frame decoder.
package dcfd_pkg;

    localparam int FRAME_BITS         = 16;
    localparam int TIME_W             = 16;
    localparam int CFG_W              = 16;
    localparam int CFG_INDEX_W        = 3;
    localparam int THROTTLE_W         = 11;
    localparam int THROTTLE_MAX       = 2047;
    localparam int LOW_THROTTLE_LIMIT = 47;
    localparam int THROTTLE_SHIFT     = 5;
    localparam int CRC_W              = 4;
    localparam int COUNT_W            = 5;
    localparam int QUEUE_DEPTH_DEF    = 2;
    localparam int OUT_DATA_W         = 32;

    // Speed interpolation: add = (thr - 47) * span / SPEED_DIV, done with a
    // reciprocal multiply followed by a single correction step.
    localparam int SPEED_DIV   = THROTTLE_MAX - LOW_THROTTLE_LIMIT;
    localparam int PROD_W      = THROTTLE_W + CFG_W;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 33;
    localparam int REM_W       = THROTTLE_W + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / SPEED_DIV);

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] GAP_TICKS_RST     = 16'd400;
    localparam logic [CFG_W-1:0] ONE_THRESHOLD_RST = 16'd100;
    localparam logic [CFG_W-1:0] LOSS_LIMIT_RST    = 16'd10;
    localparam logic [CFG_W-1:0] MIN_SPEED_RST     = 16'd500;
    localparam logic [CFG_W-1:0] MAX_SPEED_RST     = 16'd20000;
    localparam logic             CRC_INVERTED_RST  = 1'b0;

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAP_TICKS     = 3'd0,
        CFG_ONE_THRESHOLD = 3'd1,
        CFG_LOSS_LIMIT    = 3'd2,
        CFG_MIN_SPEED     = 3'd3,
        CFG_MAX_SPEED     = 3'd4,
        CFG_CRC_INVERTED  = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        WORK_PLAIN,
        WORK_FRAME,
        WORK_TIMEOUT
    } work_kind_t;

    typedef struct packed {
        work_kind_t            kind;
        logic [FRAME_BITS-1:0] frame;
    } work_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] gap_ticks;
        logic [CFG_W-1:0] one_threshold;
    } front_cfg_t;

    typedef struct packed {
        logic [CFG_W-1:0] loss_limit;
        logic [CFG_W-1:0] min_speed;
        logic [CFG_W-1:0] max_speed;
        logic             crc_inverted;
    } back_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== hw/rtl/dcfd_front.sv =====
// Front end: accepts edge and timeout transactions and assembles frame bits.
module dcfd_front
    import dcfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  front_cfg_t            cfg,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,
    input  logic [TIME_W-1:0]     s_tdata,
    input  queue_status_t         queue_status,
    output logic                  push_valid,
    output work_item_t            push_item
);

    logic [TIME_W-1:0]     last_time_reg, last_time_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  expect_reg, expect_next;
    logic                  synced_reg, synced_next;
    logic [TIME_W-1:0]     ticks;
    logic [COUNT_W-1:0]    count_inc;
    logic [FRAME_BITS-1:0] shifted;
    logic                  accept;

    assign s_tready = !queue_status.full;
    assign accept   = s_tvalid && s_tready;

    assign ticks     = s_tdata - last_time_reg;
    assign count_inc = count_reg + COUNT_W'(1);
    assign shifted   = {shift_reg[FRAME_BITS-2:0], (ticks >= cfg.one_threshold)};

    always_comb begin
        last_time_next  = last_time_reg;
        shift_next      = shift_reg;
        count_next      = count_reg;
        expect_next     = expect_reg;
        synced_next     = synced_reg;
        push_item.kind  = WORK_PLAIN;
        push_item.frame = shifted;
        if (s_tuser == OP_TIMEOUT) begin
            push_item.kind = WORK_TIMEOUT;
            shift_next     = '0;
            count_next     = '0;
            expect_next    = 1'b0;
            synced_next    = 1'b0;
        end else begin
            last_time_next = s_tdata;
            if (ticks >= cfg.gap_ticks) begin
                shift_next  = '0;
                count_next  = '0;
                expect_next = 1'b1;
                synced_next = 1'b1;
            end else if (synced_reg) begin
                if (expect_reg) begin
                    shift_next  = shifted;
                    count_next  = count_inc;
                    expect_next = 1'b0;
                    if (count_inc >= COUNT_W'(FRAME_BITS)) begin
                        push_item.kind = WORK_FRAME;
                        shift_next     = '0;
                        count_next     = '0;
                    end
                end else begin
                    expect_next = 1'b1;
                end
            end
        end
    end

    assign push_valid = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            shift_reg     <= '0;
            count_reg     <= '0;
            expect_reg    <= 1'b0;
            synced_reg    <= 1'b0;
        end else if (accept) begin
            last_time_reg <= last_time_next;
            shift_reg     <= shift_next;
            count_reg     <= count_next;
            expect_reg    <= expect_next;
            synced_reg    <= synced_next;
        end
    end

endmodule

// ===== hw/rtl/dcfd_queue.sv =====
// Small FIFO of classified work items between the front and back ends.
module dcfd_queue
    import dcfd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  work_item_t    push_item,
    input  logic          pop,
    output work_item_t    head_item,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    work_item_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_item    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/dcfd_back.sv =====
// Back end: CRC check, throttle-to-speed pipeline, timeout tracking and result register.
module dcfd_back
    import dcfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  back_cfg_t             cfg,
    input  work_item_t            head_item,
    input  queue_status_t         queue_status,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int FULL_W = PROD_W + RECIP_W;

    logic advance;

    // Stage 1: decoded frame.
    logic                  s1_valid_reg;
    work_kind_t            s1_kind_reg;
    logic                  s1_ok_reg;
    logic [THROTTLE_W-1:0] s1_thr_reg;
    logic                  s1_low_reg;
    logic [THROTTLE_W-1:0] s1_diff_reg;
    logic [CFG_W-1:0]      s1_span_reg;

    // Stage 2: scaled product.
    logic                  s2_valid_reg;
    work_kind_t            s2_kind_reg;
    logic                  s2_ok_reg;
    logic [THROTTLE_W-1:0] s2_thr_reg;
    logic                  s2_low_reg;
    logic [PROD_W-1:0]     s2_prod_reg;

    // Stage 3: quotient estimate.
    logic                  s3_valid_reg;
    work_kind_t            s3_kind_reg;
    logic                  s3_ok_reg;
    logic [THROTTLE_W-1:0] s3_thr_reg;
    logic                  s3_low_reg;
    logic [PROD_W-1:0]     s3_prod_reg;
    logic [CFG_W-1:0]      s3_quot_reg;

    // Stage 4: remainder for the correction step.
    logic                  s4_valid_reg;
    work_kind_t            s4_kind_reg;
    logic                  s4_ok_reg;
    logic [THROTTLE_W-1:0] s4_thr_reg;
    logic                  s4_low_reg;
    logic [CFG_W-1:0]      s4_quot_reg;
    logic [REM_W-1:0]      s4_rem_reg;

    // Result register and held state.
    logic                  out_valid_reg, out_valid_next;
    logic                  done_reg, done_next;
    logic                  ok_reg, ok_next;
    logic                  lost_reg, lost_next;
    logic [THROTTLE_W-1:0] held_thr_reg, held_thr_next;
    logic [CFG_W-1:0]      held_speed_reg, held_speed_next;
    logic                  running_reg, running_next;
    logic [CFG_W-1:0]      timeout_reg, timeout_next;

    logic [FRAME_BITS-CRC_W-1:0] crc_data;
    logic [CRC_W-1:0]            crc_calc;
    logic                        crc_ok;
    logic [THROTTLE_W-1:0]       thr_raw;
    logic [THROTTLE_W-1:0]       thr_clamped;
    logic                        thr_low;
    logic [CFG_W-1:0]            span;
    logic [FULL_W-1:0]           recip_prod;
    logic [PROD_W-1:0]           quot_times_div;
    logic [PROD_W-1:0]           rem_full;
    logic [CFG_W-1:0]            quot_final;
    logic [CFG_W-1:0]            timeout_inc;

    assign advance = !out_valid_reg || m_tready;
    assign pop     = advance && !queue_status.empty;

    // Stage 1 logic.
    assign crc_data = head_item.frame[FRAME_BITS-1:CRC_W];
    always_comb begin
        crc_calc = crc_data[3:0] ^ crc_data[7:4] ^ crc_data[11:8];
        if (cfg.crc_inverted) begin
            crc_calc = ~crc_calc;
        end
    end
    assign crc_ok      = (crc_calc == head_item.frame[CRC_W-1:0]);
    assign thr_raw     = head_item.frame[THROTTLE_SHIFT +: THROTTLE_W];
    assign thr_clamped = (thr_raw > THROTTLE_W'(THROTTLE_MAX)) ? THROTTLE_W'(THROTTLE_MAX)
                                                                : thr_raw;
    assign thr_low     = (thr_clamped <= THROTTLE_W'(LOW_THROTTLE_LIMIT));
    assign span        = (cfg.max_speed >= cfg.min_speed) ? cfg.max_speed - cfg.min_speed : '0;

    // Quotient estimate from the reciprocal is at most one below the true value.
    assign recip_prod     = FULL_W'(s2_prod_reg) * FULL_W'(RECIP);
    assign quot_times_div = PROD_W'(s3_quot_reg) * PROD_W'(SPEED_DIV);
    assign rem_full       = s3_prod_reg - quot_times_div;
    assign quot_final     = s4_quot_reg + CFG_W'(s4_rem_reg >= REM_W'(SPEED_DIV));
    assign timeout_inc    = (timeout_reg == '1) ? timeout_reg : timeout_reg + CFG_W'(1);

    always_comb begin
        out_valid_next  = s4_valid_reg;
        done_next       = 1'b0;
        ok_next         = 1'b0;
        held_thr_next   = held_thr_reg;
        held_speed_next = held_speed_reg;
        running_next    = running_reg;
        timeout_next    = timeout_reg;
        if (s4_valid_reg) begin
            case (s4_kind_reg)
                WORK_FRAME: begin
                    done_next = 1'b1;
                    ok_next   = s4_ok_reg;
                    if (s4_ok_reg) begin
                        timeout_next  = '0;
                        held_thr_next = s4_thr_reg;
                        if (s4_thr_reg != '0) begin
                            running_next    = 1'b1;
                            held_speed_next = s4_low_reg ? cfg.min_speed
                                                         : cfg.min_speed + quot_final;
                        end else begin
                            running_next    = 1'b0;
                            held_speed_next = '0;
                        end
                    end
                end
                WORK_TIMEOUT: begin
                    timeout_next = timeout_inc;
                    if (timeout_inc >= cfg.loss_limit) begin
                        running_next = 1'b0;
                        timeout_next = cfg.loss_limit;
                    end
                end
                default: begin
                end
            endcase
        end
        lost_next = (timeout_next >= cfg.loss_limit);
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_kind_reg <= head_item.kind;
            s1_ok_reg   <= crc_ok;
            s1_thr_reg  <= thr_clamped;
            s1_low_reg  <= thr_low;
            s1_diff_reg <= thr_low ? '0 : thr_clamped - THROTTLE_W'(LOW_THROTTLE_LIMIT);
            s1_span_reg <= span;

            s2_kind_reg <= s1_kind_reg;
            s2_ok_reg   <= s1_ok_reg;
            s2_thr_reg  <= s1_thr_reg;
            s2_low_reg  <= s1_low_reg;
            s2_prod_reg <= PROD_W'(s1_diff_reg) * PROD_W'(s1_span_reg);

            s3_kind_reg <= s2_kind_reg;
            s3_ok_reg   <= s2_ok_reg;
            s3_thr_reg  <= s2_thr_reg;
            s3_low_reg  <= s2_low_reg;
            s3_prod_reg <= s2_prod_reg;
            s3_quot_reg <= recip_prod[RECIP_SHIFT +: CFG_W];

            s4_kind_reg <= s3_kind_reg;
            s4_ok_reg   <= s3_ok_reg;
            s4_thr_reg  <= s3_thr_reg;
            s4_low_reg  <= s3_low_reg;
            s4_quot_reg <= s3_quot_reg;
            s4_rem_reg  <= rem_full[REM_W-1:0];

            done_reg    <= done_next;
            ok_reg      <= ok_next;
            lost_reg    <= lost_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            held_thr_reg   <= '0;
            held_speed_reg <= '0;
            running_reg    <= 1'b0;
            timeout_reg    <= '0;
        end else if (advance) begin
            s1_valid_reg   <= pop;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            out_valid_reg  <= out_valid_next;
            held_thr_reg   <= held_thr_next;
            held_speed_reg <= held_speed_next;
            running_reg    <= running_next;
            timeout_reg    <= timeout_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, lost_reg, running_reg, held_speed_reg, held_thr_reg,
                       ok_reg, done_reg};

endmodule

// ===== hw/rtl/dshot_capture_frame_decoder.sv =====
// Top level of the DShot capture frame decoder: configuration registers and the three stages.
//
// Input channel (s_*): one transaction per captured edge or receive timeout.
// s_tuser selects the kind (0 edge, 1 timeout); s_tdata carries the 16-bit
// timer value of the edge. Every input transaction yields exactly one result
// transaction on the m_* channel with the frame status, the held throttle and
// speed command, the run flag and the signal-lost flag.
// The front end tracks edge intervals and assembles frame bits at one
// transaction per cycle; a small queue (QUEUE_DEPTH entries) decouples it from
// the back end, a five-register pipeline that checks the CRC and computes the
// speed command with a product, a reciprocal multiply and a remainder correction.
// Throughput is one transaction per cycle while m_tready stays high.
// When m_tready is low the back-end pipeline holds, the queue fills and then
// s_tready drops until the result is taken. No result is dropped.
// Reset (aresetn low, synchronous) clears all decoder state and restores the
// configuration registers to their defaults. cfg_wr_en writes register
// cfg_index with cfg_wdata; writes are expected only while idle.
module dshot_capture_frame_decoder
    import dcfd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tuser,   // [0] operation
    input  logic [TIME_W-1:0]      s_tdata,   // [15:0] capture_time
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] frame_done, [1] crc_ok, [12:2] throttle, [28:13] speed_command,
    // [29] run_enable, [30] signal_lost, [31] zero
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    logic [CFG_W-1:0] gap_ticks_reg;
    logic [CFG_W-1:0] one_threshold_reg;
    logic [CFG_W-1:0] loss_limit_reg;
    logic [CFG_W-1:0] min_speed_reg;
    logic [CFG_W-1:0] max_speed_reg;
    logic             crc_inverted_reg;

    front_cfg_t    front_cfg;
    back_cfg_t     back_cfg;
    queue_status_t queue_status;
    logic          push_valid;
    work_item_t    push_item;
    logic          pop;
    work_item_t    head_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_ticks_reg     <= GAP_TICKS_RST;
            one_threshold_reg <= ONE_THRESHOLD_RST;
            loss_limit_reg    <= LOSS_LIMIT_RST;
            min_speed_reg     <= MIN_SPEED_RST;
            max_speed_reg     <= MAX_SPEED_RST;
            crc_inverted_reg  <= CRC_INVERTED_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_GAP_TICKS:     gap_ticks_reg     <= cfg_wdata;
                CFG_ONE_THRESHOLD: one_threshold_reg <= cfg_wdata;
                CFG_LOSS_LIMIT:    loss_limit_reg    <= cfg_wdata;
                CFG_MIN_SPEED:     min_speed_reg     <= cfg_wdata;
                CFG_MAX_SPEED:     max_speed_reg     <= cfg_wdata;
                CFG_CRC_INVERTED:  crc_inverted_reg  <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign front_cfg.gap_ticks     = gap_ticks_reg;
    assign front_cfg.one_threshold = one_threshold_reg;
    assign back_cfg.loss_limit     = loss_limit_reg;
    assign back_cfg.min_speed      = min_speed_reg;
    assign back_cfg.max_speed      = max_speed_reg;
    assign back_cfg.crc_inverted   = crc_inverted_reg;

    dcfd_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (front_cfg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tuser      (s_tuser),
        .s_tdata      (s_tdata),
        .queue_status (queue_status),
        .push_valid   (push_valid),
        .push_item    (push_item)
    );

    dcfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (queue_status)
    );

    dcfd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (back_cfg),
        .head_item    (head_item),
        .queue_status (queue_status),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

// ===== bench/dshot_capture_frame_decoder_tb.sv =====
// Self-checking testbench for the DShot capture frame decoder: random edge and timeout traffic.
module dshot_capture_frame_decoder_tb;
    import dcfd_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 30;

    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] stamp;
    } capture_item_t;

    // Mirrors the m_tdata layout, spare bit on top.
    typedef struct packed {
        logic                  spare;
        logic                  signal_lost;
        logic                  run_enable;
        logic [CFG_W-1:0]      speed_command;
        logic [THROTTLE_W-1:0] throttle;
        logic                  crc_ok;
        logic                  frame_done;
    } decoder_status_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic                   s_tuser   = 1'b0;
    logic [TIME_W-1:0]      s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    // Register values as the block should currently hold them.
    logic [CFG_W-1:0] gap_ticks_cfg     = GAP_TICKS_RST;
    logic [CFG_W-1:0] one_threshold_cfg = ONE_THRESHOLD_RST;
    logic [CFG_W-1:0] loss_limit_cfg    = LOSS_LIMIT_RST;
    logic [CFG_W-1:0] min_speed_cfg     = MIN_SPEED_RST;
    logic [CFG_W-1:0] max_speed_cfg     = MAX_SPEED_RST;
    logic             crc_inverted_cfg  = CRC_INVERTED_RST;

    // Decoder state as predicted.
    logic [TIME_W-1:0]     prev_stamp    = '0;
    logic [FRAME_BITS-1:0] frame_acc     = '0;
    logic [COUNT_W-1:0]    bits_taken    = '0;
    logic                  sample_due    = 1'b0;
    logic                  locked        = 1'b0;
    logic [CFG_W-1:0]      lapse_count   = '0;
    logic [CFG_W-1:0]      speed_hold    = '0;
    logic [THROTTLE_W-1:0] throttle_hold = '0;
    logic                  motor_on      = 1'b0;

    capture_item_t   capture_queue[$];
    decoder_status_t status_queue[$];

    int items_queued  = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int frames_total  = 0;
    int frames_good   = 0;
    int timeouts_sent = 0;
    int src_gap       = 0;
    int sink_stall    = 0;
    int mode_left     = 0;
    int quiet_cycles  = 0;
    bit in_taken      = 1'b0;
    bit idling_on     = 1'b1;
    bit final_calm    = 1'b0;
    logic [TIME_W-1:0] stamp_now = '0;

    dshot_capture_frame_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // XOR of the three upper nibbles, optionally inverted.
    function automatic logic [CRC_W-1:0] crc_nibble(input logic [FRAME_BITS-1:0] word,
                                                    input logic inv);
        logic [CRC_W-1:0] c;
        c = word[7:4] ^ word[11:8] ^ word[15:12];
        return inv ? ~c : c;
    endfunction

    function automatic logic accept_frame(input logic [FRAME_BITS-1:0] word);
        logic [THROTTLE_W-1:0] thr;
        logic [31:0]           span;
        logic [31:0]           add;
        if (crc_nibble(word, crc_inverted_cfg) != word[CRC_W-1:0]) return 1'b0;
        // An 11-bit throttle never exceeds THROTTLE_MAX, so no clamp is needed here.
        thr = word[FRAME_BITS-1:THROTTLE_SHIFT];
        lapse_count = '0;
        if (thr == '0) begin
            speed_hold = '0;
            motor_on   = 1'b0;
        end else if (thr <= LOW_THROTTLE_LIMIT) begin
            speed_hold = min_speed_cfg;
            motor_on   = 1'b1;
        end else begin
            span = (max_speed_cfg >= min_speed_cfg) ?
                   32'(max_speed_cfg) - 32'(min_speed_cfg) : 32'd0;
            add = ((32'(thr) - 32'(LOW_THROTTLE_LIMIT)) * span) / 32'(SPEED_DIV);
            speed_hold = 16'(32'(min_speed_cfg) + add);
            motor_on   = 1'b1;
        end
        throttle_hold = thr;
        return 1'b1;
    endfunction

    function automatic decoder_status_t predict_status(input capture_item_t it);
        decoder_status_t   r;
        logic [TIME_W-1:0] ticks;
        r = '0;
        if (it.op == OP_EDGE) begin
            ticks = it.stamp - prev_stamp;
            prev_stamp = it.stamp;
            if (ticks >= gap_ticks_cfg) begin
                frame_acc  = '0;
                bits_taken = '0;
                sample_due = 1'b1;
                locked     = 1'b1;
            end else if (locked) begin
                if (sample_due) begin
                    frame_acc  = {frame_acc[FRAME_BITS-2:0], ticks >= one_threshold_cfg};
                    bits_taken = bits_taken + 1'b1;
                    sample_due = 1'b0;
                    if (bits_taken >= FRAME_BITS) begin
                        r.frame_done = 1'b1;
                        r.crc_ok     = accept_frame(frame_acc);
                        frame_acc    = '0;
                        bits_taken   = '0;
                    end
                end else begin
                    sample_due = 1'b1;
                end
            end
        end else begin
            frame_acc  = '0;
            bits_taken = '0;
            sample_due = 1'b0;
            locked     = 1'b0;
            if (lapse_count != 16'hFFFF) lapse_count = lapse_count + 1'b1;
            if (lapse_count >= loss_limit_cfg) begin
                motor_on    = 1'b0;
                lapse_count = loss_limit_cfg;
            end
        end
        r.throttle      = throttle_hold;
        r.speed_command = speed_hold;
        r.run_enable    = motor_on;
        r.signal_lost   = (lapse_count >= loss_limit_cfg);
        return r;
    endfunction

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // Input and output handshakes, scoreboard and watchdog, all sampled at the rising edge.
    always @(posedge aclk) begin : track_handshakes
        capture_item_t   seen;
        decoder_status_t got;
        decoder_status_t want;
        bit              moved;
        if (aresetn) begin
            moved = 1'b0;
            if (s_tvalid && s_tready) begin
                seen.op    = s_tuser;
                seen.stamp = s_tdata;
                status_queue.push_back(predict_status(seen));
                items_taken++;
                in_taken = 1'b1;
                moved    = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got   = m_tdata;
                if (status_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result with no transaction pending, expected none, got %h",
                                 $time, m_tdata);
                end else begin
                    want = status_queue.pop_front();
                    results_seen++;
                    if (want.frame_done) frames_total++;
                    if (want.crc_ok) frames_good++;
                    check_field("frame_done", want.frame_done, got.frame_done);
                    check_field("crc_ok", want.crc_ok, got.crc_ok);
                    check_field("throttle", want.throttle, got.throttle);
                    check_field("speed_command", want.speed_command, got.speed_command);
                    check_field("run_enable", want.run_enable, got.run_enable);
                    check_field("signal_lost", want.signal_lost, got.signal_lost);
                    check_field("spare bit", want.spare, got.spare);
                end
            end
            // Alternate between stretches with random idling and stretches without.
            if (mode_left == 0) begin
                idling_on = !idling_on;
                mode_left = $urandom_range(40, 400);
            end else begin
                mode_left--;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin : feed_source
        capture_item_t nxt;
        if (aresetn && (!s_tvalid || in_taken)) begin
            in_taken = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (capture_queue.size() != 0) begin
                nxt = capture_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.op;
                s_tdata  <= nxt.stamp;
                if (idling_on && !final_calm && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 7);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : drain_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idling_on && !final_calm && $urandom_range(0, 4) == 0)
                sink_stall = $urandom_range(1, 7);
        end
    end

    task automatic queue_capture(input logic op, input logic [TIME_W-1:0] stamp);
        capture_item_t it;
        it.op    = op;
        it.stamp = stamp;
        capture_queue.push_back(it);
        items_queued++;
        if (op == OP_TIMEOUT) timeouts_sent++;
    endtask

    task automatic queue_edge_at(input logic [TIME_W-1:0] stamp);
        stamp_now = stamp;
        queue_capture(OP_EDGE, stamp_now);
    endtask

    task automatic queue_edge_after(input logic [TIME_W-1:0] ticks);
        stamp_now = stamp_now + ticks;
        queue_capture(OP_EDGE, stamp_now);
    endtask

    task automatic queue_timeout();
        queue_capture(OP_TIMEOUT, 16'($urandom));
    endtask

    function automatic bit frames_possible();
        return one_threshold_cfg != '0 && one_threshold_cfg < gap_ticks_cfg;
    endfunction

    function automatic logic [FRAME_BITS-1:0] make_word(input logic [THROTTLE_W-1:0] thr,
                                                        input bit spoil);
        logic [FRAME_BITS-1:0] w;
        w = {thr, 1'($urandom), 4'h0};
        w[CRC_W-1:0] = crc_nibble(w, crc_inverted_cfg);
        if (spoil) w[CRC_W-1:0] = w[CRC_W-1:0] ^ 4'($urandom_range(1, 15));
        return w;
    endfunction

    function automatic logic [THROTTLE_W-1:0] pick_throttle();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 11'($urandom_range(1, LOW_THROTTLE_LIMIT));
            2: return 11'($urandom_range(LOW_THROTTLE_LIMIT, LOW_THROTTLE_LIMIT + 1));
            3: return 11'(THROTTLE_MAX);
            default: return 11'($urandom_range(0, THROTTLE_MAX));
        endcase
    endfunction

    // Edge train for one frame, MSB first; a sample edge per bit and a spacer edge between bits.
    // Without resync the train follows a completed frame, so it opens with a spacer.
    task automatic queue_frame(input logic [FRAME_BITS-1:0] word, input bit resync,
                               input int keep_bits);
        int g;
        int o;
        g = gap_ticks_cfg;
        o = one_threshold_cfg;
        if (resync) queue_edge_after(16'($urandom_range(g, 65535)));
        else queue_edge_after(16'($urandom_range(0, g - 1)));
        for (int i = FRAME_BITS - 1; i >= FRAME_BITS - keep_bits; i--) begin
            if (word[i]) queue_edge_after(16'($urandom_range(o, g - 1)));
            else queue_edge_after(16'($urandom_range(0, o - 1)));
            if (i != 0) queue_edge_after(16'($urandom_range(0, g - 1)));
        end
    endtask

    task automatic run_traffic(input int budget);
        int stop_at;
        int pick;
        bit chained;
        stop_at = items_queued + budget;
        chained = 1'b0;
        while (items_queued < stop_at) begin
            pick = frames_possible() ? $urandom_range(0, 99) : $urandom_range(80, 99);
            if (pick < 70) begin
                queue_frame(make_word(pick_throttle(), $urandom_range(0, 4) == 0),
                            !chained || $urandom_range(0, 2) == 0, FRAME_BITS);
                chained = 1'b1;
            end else if (pick < 80) begin
                // Frame cut short, sometimes by a timeout.
                queue_frame(make_word(pick_throttle(), 1'b0), 1'b1,
                            $urandom_range(1, FRAME_BITS - 1));
                if ($urandom_range(0, 1)) queue_timeout();
                chained = 1'b0;
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 12)) queue_timeout();
                chained = 1'b0;
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1)) queue_edge_at(16'($urandom));
                    else queue_edge_after(16'($urandom));
                end
                chained = 1'b0;
            end
        end
    endtask

    task automatic wait_idle();
        while (items_taken != items_queued || status_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_GAP_TICKS:     gap_ticks_cfg     = value;
            CFG_ONE_THRESHOLD: one_threshold_cfg = value;
            CFG_LOSS_LIMIT:    loss_limit_cfg    = value;
            CFG_MIN_SPEED:     min_speed_cfg     = value;
            CFG_MAX_SPEED:     max_speed_cfg     = value;
            CFG_CRC_INVERTED:  crc_inverted_cfg  = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] one,
                                  input logic [CFG_W-1:0] loss, input logic [CFG_W-1:0] lo_spd,
                                  input logic [CFG_W-1:0] hi_spd, input logic inv);
        wait_idle();
        cfg_write(CFG_GAP_TICKS, gap);
        cfg_write(CFG_ONE_THRESHOLD, one);
        cfg_write(CFG_LOSS_LIMIT, loss);
        cfg_write(CFG_MIN_SPEED, lo_spd);
        cfg_write(CFG_MAX_SPEED, hi_spd);
        cfg_write(CFG_CRC_INVERTED, {15'd0, inv});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] gap;
        wait (aresetn);
        @(posedge aclk);

        // Edges before any resync only move the timestamp.
        queue_edge_at(16'h0000);
        queue_edge_at(16'hFFFF);
        // Threshold and gap boundaries, just below and exactly at each.
        queue_edge_after(16'd99);
        queue_edge_after(16'd399);
        queue_edge_after(16'd100);
        queue_edge_after(16'd400);
        queue_capture(OP_TIMEOUT, 16'hFFFF);
        queue_capture(OP_TIMEOUT, 16'h0000);
        queue_edge_at(16'h5555);
        queue_edge_at(16'hAAAA);
        // Full scale, band edges, throttle zero stopping the motor, and a bad CRC.
        queue_frame(make_word(11'(THROTTLE_MAX), 1'b0), 1'b1, FRAME_BITS);
        queue_frame(make_word(11'(LOW_THROTTLE_LIMIT + 1), 1'b0), 1'b0, FRAME_BITS);
        queue_frame(make_word(11'(LOW_THROTTLE_LIMIT), 1'b0), 1'b0, FRAME_BITS);
        queue_frame(make_word(11'd1, 1'b0), 1'b0, FRAME_BITS);
        queue_frame(make_word(11'd0, 1'b0), 1'b0, FRAME_BITS);
        queue_frame(make_word(11'd1000, 1'b1), 1'b0, FRAME_BITS);
        queue_frame(make_word(11'd1000, 1'b0), 1'b0, FRAME_BITS);
        // Enough timeouts to reach the loss limit and stay there.
        repeat (12) queue_timeout();
        queue_frame(make_word(11'd500, 1'b0), 1'b1, FRAME_BITS);
        run_traffic(120);

        // Inverted CRC, loss on the first timeout, full speed span.
        apply_settings(16'd3000, 16'd1500, 16'd1, 16'd0, 16'hFFFF, 1'b1);
        run_traffic(150);

        // Gap, loss limit and min speed at their top, one threshold just below; max speed below min speed.
        apply_settings(16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        run_traffic(130);
        // A run of timeouts well below the loss limit, then recover with a frame.
        repeat (20) queue_timeout();
        queue_frame(make_word(11'd300, 1'b0), 1'b1, FRAME_BITS);
        run_traffic(50);

        // Tightest intervals that still decode, and a loss limit of zero.
        apply_settings(16'd2, 16'd1, 16'd0, 16'd1000, 16'd1000, 1'b1);
        run_traffic(150);

        // Zero gap: every edge resyncs and no frame can complete.
        apply_settings(16'd0, 16'hFFFF, 16'd3, 16'd0, 16'd0, 1'b0);
        run_traffic(80);

        gap = 16'($urandom_range(16, 65535));
        apply_settings(gap, 16'($urandom_range(1, gap - 1)), 16'($urandom_range(1, 16)),
                       16'($urandom), 16'($urandom), 1'($urandom));
        final_calm = 1'b1;
        run_traffic(200);

        wait_idle();
        $display("Covered %0d transactions (%0d timeouts) over six register settings.",
                 items_taken, timeouts_sent);
        $display("%0d results checked, %0d frames completed, %0d passed the CRC, %0d errors.",
                 results_seen, frames_total, frames_good, error_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
